FILE: rtl/clcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the character LCD command controller.
// No dependencies; used by the top level, its checker and the testbench.
package clcd_pkg;

  localparam int unsigned Cells       = 20;
  localparam int unsigned LastCell    = Cells - 1;
  localparam int unsigned LineSplit   = 10;
  localparam int unsigned GlyphEntries = 32;

  typedef enum logic [1:0] {
    OP_CMD      = 2'd0,
    OP_DATA     = 2'd1,
    OP_RD_CHAR  = 2'd2,
    OP_RD_GLYPH = 2'd3
  } op_e;

  localparam logic [7:0] CmdSoftReset = 8'h10;

  localparam logic [3:0] FnEntry     = 4'd2;
  localparam logic [3:0] FnStep      = 4'd3;
  localparam logic [3:0] FnUnderline = 4'd4;
  localparam logic [3:0] FnBlink     = 4'd5;
  localparam logic [3:0] FnDisplay   = 4'd6;
  localparam logic [3:0] FnCursor    = 4'd7;
  localparam logic [3:0] FnLines     = 4'd9;

  function automatic logic [4:0] step_cursor(input logic [4:0] cur, input logic left,
                                             input logic two);
    logic [4:0] nxt;
    nxt = cur;
    if (left) begin
      if (cur != 5'd0 && !(two && cur == 5'(LineSplit))) begin
        nxt = cur - 5'd1;
      end
    end else begin
      if (cur < 5'(LastCell) && !(two && cur == 5'(LineSplit - 1))) begin
        nxt = cur + 5'd1;
      end
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/char_lcd_command_controller_top.sv
`timescale 1ns / 1ps
// The result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless the output stalls, set by the registered read port of the
// character and glyph memories, which doubles as the result register.
// Reset: asynchronous, clears cursor, mode flags, glyph pointers and the
// per-entry valid bits; memory contents stay, entries never written read 0.
module char_lcd_command_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] write_value_i,
  input  logic [4:0] cell_index_i,
  input  logic [1:0] glyph_index_i,
  input  logic [2:0] glyph_row_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [4:0] cursor_position_o,
  output logic       display_enabled_o,
  output logic       cursor_visible_o,
  output logic       cursor_blinking_o,
  output logic       cursor_underline_style_o,
  output logic       two_line_mode_o,
  output logic       entry_decrements_o
);

  logic [7:0] char_mem [clcd_pkg::Cells];
  logic [4:0] glyph_mem [clcd_pkg::GlyphEntries];

  logic [clcd_pkg::Cells-1:0]        char_vld_q;
  logic [clcd_pkg::GlyphEntries-1:0] glyph_vld_q;

  logic [4:0] cursor_q, cursor_d;
  logic [1:0] gsel_q, gsel_d;
  logic [2:0] grow_q, grow_d;
  logic       entry_q, entry_d;
  logic       two_q, two_d;
  logic       uline_q, uline_d;
  logic       blink_q, blink_d;
  logic       disp_q, disp_d;
  logic       curs_q, curs_d;
  logic       out_valid_q, out_valid_d;

  logic [7:0] char_rd_q;
  logic [4:0] glyph_rd_q;
  logic       rd_vld_q;
  logic       rd_glyph_q;

  logic             accept;
  clcd_pkg::op_e    op;
  logic [7:0]       v;
  logic [5:0]       set_pos;
  logic             char_we;
  logic             glyph_we;
  logic [4:0]       glyph_waddr;
  logic [4:0]       glyph_raddr;
  logic             cell_ok;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign op          = clcd_pkg::op_e'(operation_i);
  assign v           = write_value_i;
  assign set_pos     = {1'b0, v[4:0]} + (v[6] ? 6'(clcd_pkg::LineSplit) : 6'd0);
  assign glyph_waddr = {gsel_q, grow_q};
  assign glyph_raddr = {glyph_index_i, glyph_row_index_i};
  assign cell_ok     = cell_index_i < 5'(clcd_pkg::Cells);
  assign char_we     = accept && op == clcd_pkg::OP_DATA;
  assign glyph_we    = accept && op == clcd_pkg::OP_CMD && !v[7] && v[6];

  always_comb begin
    cursor_d = cursor_q;
    gsel_d   = gsel_q;
    grow_d   = grow_q;
    entry_d  = entry_q;
    two_d    = two_q;
    uline_d  = uline_q;
    blink_d  = blink_q;
    disp_d   = disp_q;
    curs_d   = curs_q;
    if (accept) begin
      case (op)
        clcd_pkg::OP_CMD: begin
          if (v[7]) begin
            cursor_d = (set_pos > 6'(clcd_pkg::LastCell)) ? 5'(clcd_pkg::LastCell)
                                                           : set_pos[4:0];
          end else if (v[6]) begin
            grow_d = grow_q + 3'd1;
          end else if (v[5]) begin
            gsel_d = v[1:0];
            grow_d = 3'd0;
          end else if (v == clcd_pkg::CmdSoftReset) begin
            cursor_d = 5'd0;
            gsel_d   = 2'd0;
            grow_d   = 3'd0;
            entry_d  = 1'b0;
            two_d    = 1'b0;
            uline_d  = 1'b0;
            blink_d  = 1'b0;
            disp_d   = 1'b0;
          end else begin
            case (v[4:1])
              clcd_pkg::FnEntry:     entry_d  = v[0];
              clcd_pkg::FnStep:      cursor_d = clcd_pkg::step_cursor(cursor_q, v[0], two_q);
              clcd_pkg::FnUnderline: uline_d  = v[0];
              clcd_pkg::FnBlink:     blink_d  = v[0];
              clcd_pkg::FnDisplay:   disp_d   = v[0];
              clcd_pkg::FnCursor:    curs_d   = v[0];
              clcd_pkg::FnLines:     two_d    = v[0];
              default: ;
            endcase
          end
        end
        clcd_pkg::OP_DATA: begin
          cursor_d = clcd_pkg::step_cursor(cursor_q, entry_q, two_q);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      gsel_q      <= '0;
      grow_q      <= '0;
      entry_q     <= 1'b0;
      two_q       <= 1'b0;
      uline_q     <= 1'b0;
      blink_q     <= 1'b0;
      disp_q      <= 1'b0;
      curs_q      <= 1'b0;
      out_valid_q <= 1'b0;
      char_vld_q  <= '0;
      glyph_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_glyph_q  <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      gsel_q      <= gsel_d;
      grow_q      <= grow_d;
      entry_q     <= entry_d;
      two_q       <= two_d;
      uline_q     <= uline_d;
      blink_q     <= blink_d;
      disp_q      <= disp_d;
      curs_q      <= curs_d;
      out_valid_q <= out_valid_d;
      if (char_we) begin
        char_vld_q[cursor_q] <= 1'b1;
      end
      if (glyph_we) begin
        glyph_vld_q[glyph_waddr] <= 1'b1;
      end
      if (accept) begin
        rd_glyph_q <= op == clcd_pkg::OP_RD_GLYPH;
        case (op)
          clcd_pkg::OP_RD_CHAR:  rd_vld_q <= cell_ok && char_vld_q[cell_index_i];
          clcd_pkg::OP_RD_GLYPH: rd_vld_q <= glyph_vld_q[glyph_raddr];
          default:               rd_vld_q <= 1'b0;
        endcase
      end
    end
  end

  // Character memory: write at cursor, registered read
  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[cursor_q] <= v;
    end
    if (accept && op == clcd_pkg::OP_RD_CHAR && cell_ok) begin
      char_rd_q <= char_mem[cell_index_i];
    end
  end

  // Glyph memory: write at loader pointer, registered read
  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= v[4:0];
    end
    if (accept && op == clcd_pkg::OP_RD_GLYPH) begin
      glyph_rd_q <= glyph_mem[glyph_raddr];
    end
  end

  assign out_valid_o              = out_valid_q;
  assign read_data_o              = !rd_vld_q  ? 8'd0 :
                                    rd_glyph_q ? {3'd0, glyph_rd_q} : char_rd_q;
  assign cursor_position_o        = cursor_q;
  assign display_enabled_o        = disp_q;
  assign cursor_visible_o         = curs_q;
  assign cursor_blinking_o        = blink_q;
  assign cursor_underline_style_o = uline_q;
  assign two_line_mode_o          = two_q;
  assign entry_decrements_o       = entry_q;

endmodule

FILE: rtl/clcd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the character LCD command controller, bound to the top.
// Depends on clcd_pkg for operation and command codes.
module clcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] operation_i,
  input logic [7:0] write_value_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic [4:0] cursor_position_o,
  input logic       display_enabled_o,
  input logic       cursor_visible_o,
  input logic       cursor_blinking_o,
  input logic       cursor_underline_style_o,
  input logic       two_line_mode_o,
  input logic       entry_decrements_o
);

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result dropped or changed");

  // Every accepted request produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted request without result");

  // Reads leave cursor, line mode and entry direction unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (operation_i == clcd_pkg::OP_RD_CHAR || operation_i == clcd_pkg::OP_RD_GLYPH)
    |=> $stable(cursor_position_o) && $stable(two_line_mode_o)
        && $stable(entry_decrements_o))
    else $error("read request changed state");

  // Soft reset clears modes but keeps cursor visibility
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && operation_i == clcd_pkg::OP_CMD && write_value_i == clcd_pkg::CmdSoftReset
    |=> cursor_position_o == 5'd0 && !display_enabled_o && !cursor_blinking_o
        && !cursor_underline_style_o && !two_line_mode_o && !entry_decrements_o
        && $stable(cursor_visible_o))
    else $error("soft reset state mismatch");

  // Writes return zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (operation_i == clcd_pkg::OP_CMD || operation_i == clcd_pkg::OP_DATA)
    |=> read_data_o == 8'd0)
    else $error("write request returned nonzero data");

endmodule

bind char_lcd_command_controller_top clcd_checker u_clcd_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .in_valid_i               (in_valid_i),
  .in_stall_o               (in_stall_o),
  .operation_i              (operation_i),
  .write_value_i            (write_value_i),
  .out_valid_o              (out_valid_o),
  .out_stall_i              (out_stall_i),
  .read_data_o              (read_data_o),
  .cursor_position_o        (cursor_position_o),
  .display_enabled_o        (display_enabled_o),
  .cursor_visible_o         (cursor_visible_o),
  .cursor_blinking_o        (cursor_blinking_o),
  .cursor_underline_style_o (cursor_underline_style_o),
  .two_line_mode_o          (two_line_mode_o),
  .entry_decrements_o       (entry_decrements_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_command_controller_top: directed and random
// bus accesses, a running model of the LCD state and an in-order result check.
// Depends on clcd_pkg for the operation codes and command constants.
module testbench;

  localparam logic [7:0]  CmdSetCursor  = 8'h80;
  localparam logic [7:0]  CmdCursorLine = 8'h40;
  localparam logic [7:0]  CmdGlyphRow   = 8'h40;
  localparam logic [7:0]  CmdGlyphSel   = 8'h20;
  localparam int unsigned RandomCount   = 1325;
  localparam int unsigned CycleLimit    = 200000;

  typedef struct {
    clcd_pkg::op_e op;
    logic [7:0]    value;
    logic [4:0]    cell_idx;
    logic [1:0]    glyph;
    logic [2:0]    row;
  } lcd_access_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [4:0] cur;
    logic       disp;
    logic       curs;
    logic       blink;
    logic       ul;
    logic       two;
    logic       dec;
  } lcd_status_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] operation = '0;
  logic [7:0] write_value = '0;
  logic [4:0] cell_index = '0;
  logic [1:0] glyph_index = '0;
  logic [2:0] glyph_row_index = '0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;
  logic [4:0] cursor_position_o;
  logic       display_enabled_o;
  logic       cursor_visible_o;
  logic       cursor_blinking_o;
  logic       cursor_underline_style_o;
  logic       two_line_mode_o;
  logic       entry_decrements_o;

  lcd_access_t pending_requests[$];
  lcd_status_t expected_status[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // model state
  logic [4:0] cursor_cell = '0;
  logic [1:0] glyph_sel = '0;
  logic [2:0] row_ptr = '0;
  logic       entry_dec = 1'b0;
  logic       two_lines = 1'b0;
  logic       underline = 1'b0;
  logic       blink_on = 1'b0;
  logic       display_on = 1'b0;
  logic       cursor_on = 1'b0;
  logic [7:0] char_mem [clcd_pkg::Cells] = '{default: 8'h00};
  logic [4:0] glyph_mem [clcd_pkg::GlyphEntries] = '{default: 5'h00};

  char_lcd_command_controller_top dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid),
    .in_stall_o               (in_stall_o),
    .operation_i              (operation),
    .write_value_i            (write_value),
    .cell_index_i             (cell_index),
    .glyph_index_i            (glyph_index),
    .glyph_row_index_i        (glyph_row_index),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall),
    .read_data_o              (read_data_o),
    .cursor_position_o        (cursor_position_o),
    .display_enabled_o        (display_enabled_o),
    .cursor_visible_o         (cursor_visible_o),
    .cursor_blinking_o        (cursor_blinking_o),
    .cursor_underline_style_o (cursor_underline_style_o),
    .two_line_mode_o          (two_line_mode_o),
    .entry_decrements_o       (entry_decrements_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] fn_cmd(input logic [3:0] fn, input logic b);
    return {3'b000, fn, b};
  endfunction

  function automatic logic [4:0] moved_cell(input logic [4:0] cur, input logic left);
    logic [4:0] nxt;
    nxt = cur;
    if (left) begin
      if (cur != 5'd0 && !(two_lines && cur == 5'(clcd_pkg::LineSplit))) nxt = cur - 5'd1;
    end else begin
      if (cur < 5'(clcd_pkg::LastCell) && !(two_lines && cur == 5'(clcd_pkg::LineSplit - 1)))
        nxt = cur + 5'd1;
    end
    return nxt;
  endfunction

  function automatic lcd_status_t predict_access(input lcd_access_t req);
    lcd_status_t s;
    logic [5:0]  pos;
    s.rd = 8'h00;
    case (req.op)
      clcd_pkg::OP_CMD: begin
        if ((req.value & CmdSetCursor) != 0) begin
          pos = {1'b0, req.value[4:0]};
          if ((req.value & CmdCursorLine) != 0) pos = pos + 6'(clcd_pkg::LineSplit);
          if (pos > 6'(clcd_pkg::LastCell)) pos = 6'(clcd_pkg::LastCell);
          cursor_cell = pos[4:0];
        end else if ((req.value & CmdGlyphRow) != 0) begin
          glyph_mem[{glyph_sel, row_ptr}] = req.value[4:0];
          row_ptr = row_ptr + 3'd1;
        end else if ((req.value & CmdGlyphSel) != 0) begin
          glyph_sel = req.value[1:0];
          row_ptr = '0;
        end else if (req.value == clcd_pkg::CmdSoftReset) begin
          cursor_cell = '0;
          glyph_sel = '0;
          row_ptr = '0;
          entry_dec = 1'b0;
          two_lines = 1'b0;
          underline = 1'b0;
          blink_on = 1'b0;
          display_on = 1'b0;
        end else begin
          case (req.value[4:1])
            clcd_pkg::FnEntry:     entry_dec = req.value[0];
            clcd_pkg::FnStep:      cursor_cell = moved_cell(cursor_cell, req.value[0]);
            clcd_pkg::FnUnderline: underline = req.value[0];
            clcd_pkg::FnBlink:     blink_on = req.value[0];
            clcd_pkg::FnDisplay:   display_on = req.value[0];
            clcd_pkg::FnCursor:    cursor_on = req.value[0];
            clcd_pkg::FnLines:     two_lines = req.value[0];
            default:               ;
          endcase
        end
      end
      clcd_pkg::OP_DATA: begin
        char_mem[cursor_cell] = req.value;
        cursor_cell = moved_cell(cursor_cell, entry_dec);
      end
      clcd_pkg::OP_RD_CHAR: begin
        if (req.cell_idx < 5'(clcd_pkg::Cells)) s.rd = char_mem[req.cell_idx];
      end
      default: s.rd = {3'b000, glyph_mem[{req.glyph, req.row}]};
    endcase
    s.cur = cursor_cell;
    s.disp = display_on;
    s.curs = cursor_on;
    s.blink = blink_on;
    s.ul = underline;
    s.two = two_lines;
    s.dec = entry_dec;
    return s;
  endfunction

  task automatic add_req(input clcd_pkg::op_e op, input logic [7:0] value,
                         input logic [4:0] cell_idx, input logic [1:0] glyph,
                         input logic [2:0] row);
    lcd_access_t req;
    req.op = op;
    req.value = value;
    req.cell_idx = cell_idx;
    req.glyph = glyph;
    req.row = row;
    pending_requests.push_back(req);
  endtask

  function automatic logic [7:0] random_command();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 15) return CmdSetCursor | 8'($urandom_range(0, 127));
    if (k < 28) return CmdGlyphRow | 8'($urandom_range(0, 31));
    if (k < 34) return CmdGlyphSel | 8'($urandom_range(0, 31));
    if (k < 36) return clcd_pkg::CmdSoftReset;
    if (k < 60) return fn_cmd(clcd_pkg::FnStep, 1'($urandom_range(0, 1)));
    if (k < 70) return fn_cmd(clcd_pkg::FnLines, 1'($urandom_range(0, 1)));
    if (k < 92) return fn_cmd(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    return 8'($urandom_range(0, 255));
  endfunction

  // driver: bursts of requests with random gaps, payload held while stalled
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : drive_proc
    lcd_access_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall_o)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        in_valid <= 1'b1;
        operation <= req.op;
        write_value <= req.value;
        cell_index <= req.cell_idx;
        glyph_index <= req.glyph;
        glyph_row_index <= req.row;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern per window, plus long holds to back up the block
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_cycle == 500 || rx_cycle == 6000) begin
      out_stall <= 1'b1;
      hold_left <= 150;
    end else begin
      if (rx_cycle % 400 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_cycle[0];
      endcase
    end
  end

  // scoreboard: predict on request acceptance, compare on result acceptance
  always @(posedge clk_i) begin : score_proc
    lcd_access_t req;
    lcd_status_t want;
    lcd_status_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        req.op = clcd_pkg::op_e'(operation);
        req.value = write_value;
        req.cell_idx = cell_index;
        req.glyph = glyph_index;
        req.row = glyph_row_index;
        expected_status.push_back(predict_access(req));
      end
      if (out_valid_o && !out_stall) begin
        got = '{read_data_o, cursor_position_o, display_enabled_o, cursor_visible_o,
                cursor_blinking_o, cursor_underline_style_o, two_line_mode_o,
                entry_decrements_o};
        if (expected_status.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result at cycle %0d", cycle_count);
        end else begin
          want = expected_status.pop_front();
          if (got.rd !== want.rd || got.cur !== want.cur || got.disp !== want.disp ||
              got.curs !== want.curs || got.blink !== want.blink || got.ul !== want.ul ||
              got.two !== want.two || got.dec !== want.dec) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("mismatch at cycle %0d: exp rd=%h cur=%0d flags=%b",
                       cycle_count, want.rd, want.cur,
                       {want.disp, want.curs, want.blink, want.ul, want.two, want.dec});
              $display("                     got rd=%h cur=%0d flags=%b",
                       got.rd, got.cur,
                       {got.disp, got.curs, got.blink, got.ul, got.two, got.dec});
            end
          end
        end
      end
    end
  end

  initial begin
    int unsigned k;
    lcd_access_t req;
    // directed part
    add_req(clcd_pkg::OP_RD_CHAR, 8'h00, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_RD_GLYPH, 8'hff, 5'd31, 2'd3, 3'd7);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnDisplay, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnCursor, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnBlink, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnUnderline, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnLines, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnEntry, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdSetCursor | 8'h0a, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_DATA, 8'hff, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, 8'hdf, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnStep, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdSetCursor | 8'h09, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnStep, 1'b0), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdSetCursor, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, fn_cmd(clcd_pkg::FnStep, 1'b1), 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdGlyphSel | 8'h03, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdGlyphRow | 8'h1f, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, CmdGlyphRow, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_RD_GLYPH, 8'h00, 5'd0, 2'd3, 3'd0);
    add_req(clcd_pkg::OP_RD_CHAR, 8'h00, 5'd31, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_RD_CHAR, 8'h00, 5'd10, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, clcd_pkg::CmdSoftReset, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_CMD, 8'h11, 5'd0, 2'd0, 3'd0);
    add_req(clcd_pkg::OP_DATA, 8'h00, 5'd0, 2'd0, 3'd0);

    // random part: mostly meaningful commands and writes, random don't-care fields
    for (int unsigned n = 0; n < RandomCount; n++) begin
      req.value = 8'($urandom_range(0, 255));
      req.cell_idx = 5'($urandom_range(0, 31));
      req.glyph = 2'($urandom_range(0, 3));
      req.row = 3'($urandom_range(0, 7));
      k = $urandom_range(0, 99);
      if (k < 40) begin
        req.op = clcd_pkg::OP_CMD;
        req.value = random_command();
      end else if (k < 65) begin
        req.op = clcd_pkg::OP_DATA;
      end else if (k < 82) begin
        req.op = clcd_pkg::OP_RD_CHAR;
        if ($urandom_range(0, 7) != 0)
          req.cell_idx = 5'($urandom_range(0, clcd_pkg::LastCell));
      end else begin
        req.op = clcd_pkg::OP_RD_GLYPH;
      end
      pending_requests.push_back(req);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_requests.size() != 0 || in_valid || expected_status.size() != 0) &&
           cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
    end else begin
      repeat (8) @(posedge clk_i);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
        $display("testbench passed");
      end else begin
        $display("testbench failed");
      end
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/clcd_pkg.sv
rtl/char_lcd_command_controller_top.sv
rtl/clcd_checker.sv
tb/testbench.sv
